// File: design/psgpi_pkg.sv
// ---------------------------------------------------------------------------
// psgpi_pkg: shared types and constants of the PSG pitch interpolator
// Default parameters, reciprocal constants, item codes and sequencer states.
// ---------------------------------------------------------------------------
package psgpi_pkg;

  // Default sizing
  localparam int TABLE_DEPTH_DEF   = 86;
  localparam int KEY_SPAN_DEF      = 84;
  localparam int TONE_CHANNELS_DEF = 3;

  // Field widths
  localparam int WORD_W  = 16;
  localparam int MUL_W   = 32;
  localparam int LOAD_IW = 7;

  // Key reduction: floor(u / KEY_SPAN) = (u * ceil(2^24 / KEY_SPAN)) >> 24
  localparam int KEY_RECIP_SHIFT = 24;

  // Division by 255: floor(x / 255) = (x * 0x80808081) >> 39 for x < 2^31
  localparam logic [MUL_W-1:0] INTERP_RECIP = 32'h8080_8081;
  localparam int               INTERP_SHIFT = 39;

  localparam int LENGTH_ENABLE_BIT = 14;

  // Item codes
  localparam logic KIND_PITCH = 1'b0;
  localparam logic KIND_LOAD  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RECIP,
    ST_QUOT,
    ST_REM,
    ST_RD_BASE,
    ST_RD_NEXT,
    ST_DELTA,
    ST_SCALE,
    ST_FREQ,
    ST_EMIT
  } seq_state_t;

endpackage

// File: design/psgpi_req_if.sv
// ---------------------------------------------------------------------------
// psgpi_req_if: request channel of the PSG pitch interpolator
// Carries pitch requests and pitch table loads with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface psgpi_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic signed [15:0] pitch_key;
  logic signed [15:0] pitch_fraction;
  logic [1:0]  channel;
  logic        length_enable_now;
  logic [6:0]  load_index;
  logic [15:0] load_word;

  modport source (
    output valid, kind, pitch_key, pitch_fraction, channel, length_enable_now,
           load_index, load_word,
    input  ready
  );

  modport sink (
    input  valid, kind, pitch_key, pitch_fraction, channel, length_enable_now,
           load_index, load_word,
    output ready
  );
endinterface

// File: design/psgpi_rsp_if.sv
// ---------------------------------------------------------------------------
// psgpi_rsp_if: response channel of the PSG pitch interpolator
// Carries frequency register writes with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface psgpi_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  write_channel;
  logic [15:0] register_word;

  modport source (
    output valid, write_channel, register_word,
    input  ready
  );

  modport sink (
    input  valid, write_channel, register_word,
    output ready
  );
endinterface

// File: design/psgpi_ram.sv
// ---------------------------------------------------------------------------
// psgpi_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module psgpi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 86
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/psgpi_mul.sv
// ---------------------------------------------------------------------------
// psgpi_mul: shared unsigned multiplier
// 32 x 32 unsigned product, registered; result valid in the cycle after issue.
// ---------------------------------------------------------------------------
module psgpi_mul (
  input  logic                           clk,
  input  logic [psgpi_pkg::MUL_W-1:0]    a,
  input  logic [psgpi_pkg::MUL_W-1:0]    b,
  output logic [2*psgpi_pkg::MUL_W-1:0]  p
);

  always_ff @(posedge clk) begin
    p <= (2*psgpi_pkg::MUL_W)'(a) * (2*psgpi_pkg::MUL_W)'(b);
  end

endmodule

// File: design/psg_pitch_interpolator.sv
// ---------------------------------------------------------------------------
// psg_pitch_interpolator: pitch-to-frequency lookup with linear interpolation
// Sequencer around one shared multiplier and a pitch table RAM with one write and one read port.
// ---------------------------------------------------------------------------
// Load words write the pitch table and never produce a response. A pitch
// request is taken only in idle; for a channel below TONE_CHANNELS it then
// occupies the block through RECIP, QUOT, REM, RD_BASE, RD_NEXT, then
// DELTA, SCALE and FREQ when the fraction is nonzero, and EMIT; for any
// other channel it does no work. The shared multiplier runs four times per
// interpolated request (key reciprocal, quotient back-multiply, delta times
// fraction, reciprocal of 255), and the table RAM's one read port fetches
// the two neighboring entries in turn. A result that matches the channel's
// cached frequency is dropped; any other result is held in the output
// register until taken, while the block already accepts the next word.
// Table entries must be loaded before they are read.
// ---------------------------------------------------------------------------
module psg_pitch_interpolator #(
  parameter int TABLE_DEPTH   = psgpi_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_SPAN      = psgpi_pkg::KEY_SPAN_DEF,
  parameter int TONE_CHANNELS = psgpi_pkg::TONE_CHANNELS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  psgpi_req_if.sink  req,
  psgpi_rsp_if.source rsp
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int KW = $clog2(KEY_SPAN);
  localparam int IW = $clog2(KEY_SPAN + TABLE_DEPTH + 2);
  localparam int CW = (TONE_CHANNELS > 1) ? $clog2(TONE_CHANNELS) : 1;
  localparam int WW = psgpi_pkg::WORD_W;
  localparam int MW = psgpi_pkg::MUL_W;
  localparam logic [MW-1:0] KEY_RECIP =
    MW'(((1 << psgpi_pkg::KEY_RECIP_SHIFT) + KEY_SPAN - 1) / KEY_SPAN);

  // Sequencer
  psgpi_pkg::seq_state_t state, state_next;

  // Request context
  logic          key_neg;
  logic [WW-1:0] key_mag;
  logic          frac_neg;
  logic [WW-1:0] frac_mag;
  logic          frac_zero;
  logic [CW-1:0] ch_idx;
  logic [1:0]    ch_out;
  logic          len_bit;
  logic [KW-1:0] k;
  logic          ok_base;
  logic          ok_next;
  logic [WW-1:0] base;
  logic          prod_neg;
  logic [WW-1:0] freq;

  // Per-channel frequency cache
  logic [WW-1:0] last_freq [TONE_CHANNELS];

  // Output register
  logic          rsp_valid;
  logic [1:0]    write_channel;
  logic [WW-1:0] register_word;

  // Shared multiplier
  logic [MW-1:0]   mul_a, mul_b;
  logic [2*MW-1:0] mul_p;

  // Table RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [WW-1:0] ram_rdata;

  // Datapath helpers
  logic          req_fire;
  logic          pitch_go;
  logic [IW-1:0] idx_base, idx_next;
  logic [WW-1:0] rem;
  logic [WW-1:0] next_word;
  logic [WW-1:0] delta;
  logic [WW-1:0] delta_mag;
  logic [WW-1:0] qmag;
  logic          freq_changed;
  logic          out_free;
  logic          emit_load;

  psgpi_ram #(
    .WIDTH (WW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req.load_word),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  psgpi_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign req_fire = req.valid && req.ready;
  assign pitch_go = req_fire && (req.kind == psgpi_pkg::KIND_PITCH) &&
                    (int'(req.channel) < TONE_CHANNELS);

  // Load words go straight into the table; out-of-range indexes are dropped
  assign ram_we    = req_fire && (req.kind == psgpi_pkg::KIND_LOAD) &&
                     (int'(req.load_index) < TABLE_DEPTH);
  assign ram_waddr = AW'(req.load_index);

  // Neighbor indexes after the wrap; beyond the table they read as zero
  assign idx_base = IW'(k) + IW'(1);
  assign idx_next = IW'(k) + IW'(2);

  // Remainder of the key magnitude after the quotient back-multiply
  assign rem = key_mag - mul_p[WW-1:0];

  // Signed 16-bit delta to the upper neighbor, as sign and magnitude
  assign next_word = ok_next ? ram_rdata : '0;
  assign delta     = next_word - base;
  assign delta_mag = delta[WW-1] ? (WW'(0) - delta) : delta;

  // Quotient magnitude of the scaled product over 255
  assign qmag = mul_p[psgpi_pkg::INTERP_SHIFT +: WW];

  assign freq_changed = (freq != last_freq[ch_idx]);
  assign out_free     = !rsp_valid || rsp.ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      psgpi_pkg::ST_IDLE: begin
        if (pitch_go) state_next = psgpi_pkg::ST_RECIP;
      end
      psgpi_pkg::ST_RECIP:   state_next = psgpi_pkg::ST_QUOT;
      psgpi_pkg::ST_QUOT:    state_next = psgpi_pkg::ST_REM;
      psgpi_pkg::ST_REM:     state_next = psgpi_pkg::ST_RD_BASE;
      psgpi_pkg::ST_RD_BASE: state_next = psgpi_pkg::ST_RD_NEXT;
      psgpi_pkg::ST_RD_NEXT: begin
        state_next = frac_zero ? psgpi_pkg::ST_EMIT : psgpi_pkg::ST_DELTA;
      end
      psgpi_pkg::ST_DELTA:   state_next = psgpi_pkg::ST_SCALE;
      psgpi_pkg::ST_SCALE:   state_next = psgpi_pkg::ST_FREQ;
      psgpi_pkg::ST_FREQ:    state_next = psgpi_pkg::ST_EMIT;
      psgpi_pkg::ST_EMIT: begin
        if (!freq_changed || out_free) state_next = psgpi_pkg::ST_IDLE;
      end
      default: state_next = psgpi_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, multiplier operands, table read address
  always_comb begin
    req.ready = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    ram_raddr = '0;
    emit_load = 1'b0;
    unique case (state)
      psgpi_pkg::ST_IDLE: begin
        req.ready = 1'b1;
      end
      psgpi_pkg::ST_RECIP: begin
        mul_a = MW'(key_mag);
        mul_b = KEY_RECIP;
      end
      psgpi_pkg::ST_QUOT: begin
        mul_a = MW'(mul_p[psgpi_pkg::KEY_RECIP_SHIFT +: WW]);
        mul_b = MW'(KEY_SPAN);
      end
      psgpi_pkg::ST_REM: begin
      end
      psgpi_pkg::ST_RD_BASE: begin
        ram_raddr = idx_base[AW-1:0];
      end
      psgpi_pkg::ST_RD_NEXT: begin
        ram_raddr = idx_next[AW-1:0];
      end
      psgpi_pkg::ST_DELTA: begin
        mul_a = MW'(delta_mag);
        mul_b = MW'(frac_mag);
      end
      psgpi_pkg::ST_SCALE: begin
        mul_a = mul_p[MW-1:0];
        mul_b = psgpi_pkg::INTERP_RECIP;
      end
      psgpi_pkg::ST_FREQ: begin
      end
      psgpi_pkg::ST_EMIT: begin
        emit_load = freq_changed && out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psgpi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (pitch_go) begin
      key_neg   <= req.pitch_key[WW-1];
      key_mag   <= req.pitch_key[WW-1] ? (WW'(0) - $unsigned(req.pitch_key))
                                       : $unsigned(req.pitch_key);
      frac_neg  <= req.pitch_fraction[WW-1];
      frac_mag  <= req.pitch_fraction[WW-1]
                   ? (WW'(0) - $unsigned(req.pitch_fraction))
                   : $unsigned(req.pitch_fraction);
      frac_zero <= (req.pitch_fraction == '0);
      ch_idx    <= CW'(req.channel);
      ch_out    <= req.channel;
      len_bit   <= req.length_enable_now;
    end
    case (state)
      psgpi_pkg::ST_REM: begin
        // Fold a negative key up into 0..KEY_SPAN-1
        k <= (key_neg && (rem != '0)) ? (KW'(KEY_SPAN) - rem[KW-1:0]) : rem[KW-1:0];
      end
      psgpi_pkg::ST_RD_BASE: begin
        ok_base <= (idx_base < IW'(TABLE_DEPTH));
      end
      psgpi_pkg::ST_RD_NEXT: begin
        ok_next <= (idx_next < IW'(TABLE_DEPTH));
        base    <= ok_base ? ram_rdata : '0;
        freq    <= ok_base ? ram_rdata : '0;
      end
      psgpi_pkg::ST_DELTA: begin
        prod_neg <= delta[WW-1] ^ frac_neg;
      end
      psgpi_pkg::ST_FREQ: begin
        freq <= prod_neg ? (base - qmag) : (base + qmag);
      end
      default: begin
      end
    endcase
    if (emit_load) begin
      write_channel <= ch_out;
      register_word <= freq | (WW'(len_bit) << psgpi_pkg::LENGTH_ENABLE_BIT);
    end
  end

  // Frequency cache: update only on an emitted change
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TONE_CHANNELS; i++) begin
        last_freq[i] <= '0;
      end
    end else if (emit_load) begin
      last_freq[ch_idx] <= freq;
    end
  end

  // Output valid: hold until taken, reload on a new result
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.write_channel = write_channel;
  assign rsp.register_word = register_word;

endmodule
